### design/hfs_pkg.sv
// Shared constants and the gamma threshold table for the half-float to sRGB pixel block.
// The table is computed at elaboration by exact integer arithmetic; no other dependencies.
package hfs_pkg;

  localparam int NUM_LANES    = 3;
  localparam int CHAN_W       = 16;
  localparam int BYTE_W       = 8;
  localparam int KEY_W        = 15;
  localparam int SEARCH_STEPS = 8;
  localparam int PIPE_DEPTH   = SEARCH_STEPS + 1;
  localparam int IN_DATA_W    = NUM_LANES * CHAN_W;
  localparam int OUT_DATA_W   = NUM_LANES * BYTE_W;

  // fp16 exponent codes with a special meaning.
  localparam logic [4:0] EXP_SPECIAL = 5'd31;
  localparam logic [4:0] EXP_ONE     = 5'd15;
  localparam logic [4:0] EXP_ZERO    = 5'd0;
  // First fp16 code at 1.0; every level is reached there.
  localparam int CODE_ONE = 32'h3C00;

  // True when the positive fp16 code reaches gamma level k, that is
  // 255^11 * x^5 >= k^11 with x = mant * 2^-(shift/5).
  function automatic bit code_reaches(input logic [KEY_W-1:0] code, input int k);
    logic [255:0] lhs;
    logic [255:0] rhs;
    logic [10:0]  mant;
    int           shift;
    int           i;
    if (code[14:10] == EXP_ZERO) begin
      mant  = {1'b0, code[9:0]};
      shift = 120;
    end else begin
      mant  = {1'b1, code[9:0]};
      shift = 5 * (25 - int'(code[14:10]));
    end
    lhs = 256'd1;
    rhs = 256'd1;
    for (i = 0; i < 11; i++) begin
      lhs = lhs * 256'd255;
      rhs = rhs * 256'(k);
    end
    for (i = 0; i < 5; i++) begin
      lhs = lhs * 256'(mant);
    end
    rhs = rhs << shift;
    return (mant != 11'd0) && (lhs >= rhs);
  endfunction

  // Smallest fp16 code that reaches level k, found by bisection.
  function automatic logic [KEY_W-1:0] level_threshold(input int k);
    int lo;
    int hi;
    int mid;
    lo = 1;
    hi = CODE_ONE;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (code_reaches(KEY_W'(mid), k)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return KEY_W'(lo);
  endfunction

  // Entry k is the first code that maps to level k or above; entry 0 is zero.
  function automatic logic [255:0][KEY_W-1:0] build_thresholds();
    logic [255:0][KEY_W-1:0] tbl;
    int k;
    tbl[0] = '0;
    for (k = 1; k < 256; k++) begin
      tbl[k] = level_threshold(k);
    end
    return tbl;
  endfunction

  localparam logic [255:0][KEY_W-1:0] THRESH = build_thresholds();

endpackage

### design/hfs_lane.sv
// One channel lane: fp16 decode with special cases, then an eight-step pipelined
// bisection over the gamma threshold table. Depends on hfs_pkg.
module hfs_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          mode_half,
  input  logic [hfs_pkg::CHAN_W-1:0]    chan_in,
  output logic [hfs_pkg::BYTE_W-1:0]    byte_out
);

  typedef struct packed {
    logic [hfs_pkg::KEY_W-1:0]  key;
    logic [hfs_pkg::BYTE_W-1:0] acc;
    logic                       ovr_en;
    logic [hfs_pkg::BYTE_W-1:0] ovr_val;
  } stage_t;

  stage_t     stage_r [hfs_pkg::SEARCH_STEPS+1];
  stage_t     entry_nxt;
  logic       sign;
  logic [4:0] ex;
  logic [9:0] fr;

  assign sign = chan_in[15];
  assign ex   = chan_in[14:10];
  assign fr   = chan_in[9:0];

  // Entry stage: byte mode and the fp16 special values bypass the search.
  always_comb begin
    entry_nxt.key     = chan_in[hfs_pkg::KEY_W-1:0];
    entry_nxt.acc     = '0;
    entry_nxt.ovr_en  = 1'b1;
    entry_nxt.ovr_val = '0;
    if (!mode_half) begin
      entry_nxt.ovr_val = chan_in[hfs_pkg::BYTE_W-1:0];
    end else if (ex == hfs_pkg::EXP_SPECIAL) begin
      entry_nxt.ovr_val = (fr == 10'd0 && !sign) ? '1 : '0;
    end else if (sign) begin
      entry_nxt.ovr_val = '0;
    end else if (ex >= hfs_pkg::EXP_ONE) begin
      entry_nxt.ovr_val = '1;
    end else begin
      entry_nxt.ovr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r[0] <= entry_nxt;
    end
  end

  // Each step decides one result bit, most significant first.
  for (genvar j = 0; j < hfs_pkg::SEARCH_STEPS; j++) begin : g_step
    stage_t                     step_nxt;
    logic [hfs_pkg::BYTE_W-1:0] cand;

    always_comb begin
      cand     = stage_r[j].acc | hfs_pkg::BYTE_W'(1 << (hfs_pkg::SEARCH_STEPS - 1 - j));
      step_nxt = stage_r[j];
      if (stage_r[j].key >= hfs_pkg::THRESH[cand]) begin
        step_nxt.acc = cand;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[j+1] <= step_nxt;
      end
    end
  end

  assign byte_out = stage_r[hfs_pkg::SEARCH_STEPS].ovr_en ?
                    stage_r[hfs_pkg::SEARCH_STEPS].ovr_val :
                    stage_r[hfs_pkg::SEARCH_STEPS].acc;

endmodule

### design/half_float_to_srgb_pixel.sv
// Top level of the half-float to sRGB pixel converter: three channel lanes and the
// merging output register. Depends on hfs_pkg and hfs_lane.
//
// The block takes one RGB pixel per cycle unless its output stalls and returns it as
// blue, green and red bytes. With the mode bit clear each channel's low byte passes
// through; with it set each channel is read as fp16 linear light and gamma encoded as
// floor(255 * x^(1/2.2)), with values of one or more and plus infinity giving 255 and
// negatives and NaN giving 0. Throughput is one pixel per cycle unless stalled; an
// accepted input beat passes through the entry register, the eight bisection steps over
// the 256-entry threshold table in each lane and the output register before its output
// beat is offered. The pipeline advances as a whole whenever the output register is
// empty or being taken. Write the mode register only while no pixel is in flight.
module half_float_to_srgb_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  // Fields from bit 0: red_in[15:0], green_in[31:16], blue_in[47:32].
  input  logic [hfs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: blue_out[7:0], green_out[15:8], red_out[23:16].
  output logic [hfs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);

  logic                                  mode_r;
  logic [hfs_pkg::PIPE_DEPTH-1:0]        valid_r;
  logic [hfs_pkg::PIPE_DEPTH-1:0]        valid_nxt;
  logic                                  out_valid_r;
  logic [hfs_pkg::OUT_DATA_W-1:0]        out_tdata_r;
  logic [hfs_pkg::OUT_DATA_W-1:0]        out_tdata_nxt;
  logic [hfs_pkg::BYTE_W-1:0]            lane_byte [hfs_pkg::NUM_LANES];
  logic                                  advance;

  // The pipe moves when the output register is free or its beat is taken.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign cfg_ready = 1'b1;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Lanes: red, green, blue.
  for (genvar i = 0; i < hfs_pkg::NUM_LANES; i++) begin : g_lane
    hfs_lane u_lane (
      .clk       (clk),
      .en        (advance),
      .mode_half (mode_r),
      .chan_in   (in_tdata[i*hfs_pkg::CHAN_W +: hfs_pkg::CHAN_W]),
      .byte_out  (lane_byte[i])
    );
  end

  // Merge into blue, green, red byte order.
  assign out_tdata_nxt = {lane_byte[0], lane_byte[1], lane_byte[2]};
  assign valid_nxt     = {valid_r[hfs_pkg::PIPE_DEPTH-2:0], in_tvalid};

  // Stage valid bits and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      valid_r     <= valid_nxt;
      out_valid_r <= valid_r[hfs_pkg::PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_valid_r;

  // An accepted beat always enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[0])
    else $error("accepted input beat did not enter the pipeline");

  // A stalled output freezes every stage behind it.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(valid_r) && $stable(out_tdata_r))
    else $error("pipeline moved while the output was stalled");

  // The last stage hands its beat to the output register when the pipe moves.
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && valid_r[hfs_pkg::PIPE_DEPTH-1] |=> out_valid_r)
    else $error("beat lost between the last stage and the output register");

endmodule

### dv/hfs_pixel_checker.sv
`timescale 1ns / 1ps
// Scoreboard for half_float_to_srgb_pixel: watches the input, output and mode channels,
// predicts each output pixel and compares it lane by lane. Depends on hfs_pkg.
module hfs_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hfs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hfs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_data,
  output int                             errors,
  output int                             pending
);

  localparam int BYTE_W = hfs_pkg::BYTE_W;
  localparam int CHAN_W = hfs_pkg::CHAN_W;
  localparam int LANES  = hfs_pkg::NUM_LANES;

  // Our copy of the mode register and the pixels still owed by the block,
  // kept in the output beat layout (blue in the low byte).
  logic                           half_mode;
  logic [hfs_pkg::OUT_DATA_W-1:0] owed_pixels[$];

  // Gamma level of one fp16 code: the largest k in 0..254 with
  // 255^11 * x^5 >= k^11, where x = mant * 2^-(shift/5); saturation handled first.
  function automatic logic [BYTE_W-1:0] gamma_level(input logic [CHAN_W-1:0] code);
    logic [255:0] scaled_x;
    logic [255:0] level_pow;
    logic [255:0] mid_wide;
    logic [10:0]  mant;
    int           shift;
    int           lo;
    int           hi;
    int           mid;
    int           i;
    if (code[14:10] == hfs_pkg::EXP_SPECIAL) begin
      // Plus infinity saturates; NaN and minus infinity give black.
      return (code[9:0] == 10'd0 && !code[15]) ? 8'hFF : 8'h00;
    end
    if (code[15]) begin
      return 8'h00;
    end
    if (code[14:10] >= hfs_pkg::EXP_ONE) begin
      return 8'hFF;
    end
    if (code[14:10] == hfs_pkg::EXP_ZERO) begin
      mant  = {1'b0, code[9:0]};
      shift = 120;
    end else begin
      mant  = {1'b1, code[9:0]};
      shift = 5 * (25 - int'(code[14:10]));
    end
    if (mant == 11'd0) begin
      return 8'h00;
    end
    scaled_x = 256'd1;
    for (i = 0; i < 11; i++) begin
      scaled_x = scaled_x * 256'd255;
    end
    for (i = 0; i < 5; i++) begin
      scaled_x = scaled_x * {245'd0, mant};
    end
    // Bisection over the candidate levels.
    lo = 0;
    hi = 254;
    while (lo < hi) begin
      mid       = (lo + hi + 1) / 2;
      mid_wide  = 256'(mid);
      level_pow = 256'd1;
      for (i = 0; i < 11; i++) begin
        level_pow = level_pow * mid_wide;
      end
      level_pow = level_pow << shift;
      if (scaled_x >= level_pow) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return BYTE_W'(lo);
  endfunction

  // Output pixel for one input beat: lanes come out in reverse order (blue first).
  function automatic logic [hfs_pkg::OUT_DATA_W-1:0] predict_pixel(
      input logic [hfs_pkg::IN_DATA_W-1:0] beat, input logic gamma_on);
    logic [hfs_pkg::OUT_DATA_W-1:0] pixel;
    logic [CHAN_W-1:0]              chan;
    int                             lane;
    for (lane = 0; lane < LANES; lane++) begin
      chan = beat[CHAN_W*lane +: CHAN_W];
      pixel[BYTE_W*(LANES-1-lane) +: BYTE_W] = gamma_on ? gamma_level(chan) : chan[7:0];
    end
    return pixel;
  endfunction

  string lane_names[LANES] = '{"blue", "green", "red"};

  // Track every handshake at the clock edge and compare delivered pixels.
  always @(posedge clk) begin
    logic [hfs_pkg::OUT_DATA_W-1:0] want;
    int                             bad;
    int                             lane;
    bad = 0;
    if (!rst_n) begin
      half_mode <= 1'b0;
      owed_pixels.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_pixels.size() == 0) begin
          $display("%0t: output beat %h arrived with no pixel pending", $time, out_tdata);
          bad = bad + 1;
        end else begin
          want = owed_pixels.pop_front();
          for (lane = 0; lane < LANES; lane++) begin
            if (out_tdata[BYTE_W*lane +: BYTE_W] !== want[BYTE_W*lane +: BYTE_W]) begin
              $display("%0t: %s byte expected %h, got %h", $time, lane_names[lane],
                       want[BYTE_W*lane +: BYTE_W], out_tdata[BYTE_W*lane +: BYTE_W]);
              bad = bad + 1;
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        owed_pixels.push_back(predict_pixel(in_tdata, half_mode));
      end
      if (cfg_valid && cfg_ready) begin
        half_mode <= cfg_data;
      end
      pending <= owed_pixels.size();
    end
    errors <= errors + bad;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for half_float_to_srgb_pixel: clock, reset, pixel and mode stimulus
// with random idling, and the verdict. Depends on hfs_pkg and hfs_pixel_checker.
module tb;

  localparam int CHAN_W   = hfs_pkg::CHAN_W;
  localparam int SETTLE   = 16;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_HALF = 1'b1;

  logic                           clk;
  logic                           rst_n;
  logic [hfs_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [hfs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_data;
  int                             errors;
  int                             pending;
  // While set, neither side idles.
  logic                           steady;

  half_float_to_srgb_pixel u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  hfs_pixel_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous upper bound on the whole run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Output side: stall in about one cycle of ten unless a steady stretch is on.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Present one pixel beat, idling at random first, and wait for its handshake.
  task automatic send_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                            input logic [CHAN_W-1:0] blue);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {blue, green, red};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted pixel has come out.
  task automatic drain_pixels();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mode register write; only called with the pipeline empty.
  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Channel code for half mode: mostly in the gamma range, some subnormals,
  // codes around one, infinities and NaNs, and fully random patterns.
  function automatic logic [CHAN_W-1:0] random_half_code();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      5: begin
        return CHAN_W'($urandom_range(0, 16'h03FF));
      end
      6: begin
        return CHAN_W'($urandom_range(16'h3B00, 16'h3C3F));
      end
      7: begin
        return {1'($urandom_range(0, 1)), hfs_pkg::EXP_SPECIAL, 10'($urandom())};
      end
      8, 9: begin
        return CHAN_W'($urandom());
      end
      default: begin
        return CHAN_W'($urandom_range(0, 16'h3BFF));
      end
    endcase
  endfunction

  // Edge codes for half mode: signed zeros, subnormal ends, the normal range around
  // one, infinities, quiet and signaling NaNs, and negatives.
  logic [CHAN_W-1:0] edge_codes[18] = '{
    16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h0200,
    16'h3800, 16'h3BFF, 16'h3C00, 16'h3C01, 16'h7BFF, 16'h7C00,
    16'hFC00, 16'h7E00, 16'hFE00, 16'h7C01, 16'hBC00, 16'h8001
  };

  // Byte mode patterns, with the ignored upper bits set and clear.
  logic [CHAN_W-1:0] byte_codes[6] = '{
    16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'hA55A, 16'h5AA5
  };

  initial begin
    int n;
    int i;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    steady     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Byte mode straight out of reset, lanes rotated so each sees every pattern.
    n = $size(byte_codes);
    for (i = 0; i < n; i++) begin
      send_pixel(byte_codes[i], byte_codes[(i + 2) % n], byte_codes[(i + 4) % n]);
    end
    drain_pixels();

    // Half mode edge cases.
    write_mode(MODE_HALF);
    n = $size(edge_codes);
    for (i = 0; i < n; i++) begin
      send_pixel(edge_codes[i], edge_codes[(i + 5) % n], edge_codes[(i + 11) % n]);
    end

    // Random half mode pixels, with one full stop in the middle and a stretch
    // with no idling on either side.
    for (i = 0; i < 260; i++) begin
      if (i == 120) begin
        drain_pixels();
      end
      steady = (i >= 150 && i < 230);
      send_pixel(random_half_code(), random_half_code(), random_half_code());
    end
    steady = 1'b0;
    drain_pixels();

    // Random byte mode pixels.
    write_mode(MODE_BYTE);
    for (i = 0; i < 140; i++) begin
      send_pixel(CHAN_W'($urandom()), CHAN_W'($urandom()), CHAN_W'($urandom()));
    end
    drain_pixels();

    // Back to half mode for the rest.
    write_mode(MODE_HALF);
    for (i = 0; i < 250; i++) begin
      send_pixel(random_half_code(), random_half_code(), random_half_code());
    end
    drain_pixels();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
